/* design/tmr_pkg.sv */
// Shared types and constants for the tachometer median rpm block.
// Holds widths, reset values, status and opcode codes and the controller structs.
// No dependencies; every other design file uses it.
package tmr_pkg;

  // Median ring geometry.
  localparam int unsigned MEDIAN_DEPTH = 5;
  localparam int unsigned RING_IDX_W   = $clog2(MEDIAN_DEPTH);
  localparam int unsigned CNT_W        = $clog2(MEDIAN_DEPTH + 1);

  // Field and register widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PPR_W      = 16;
  localparam int unsigned MINP_W     = 20;
  localparam int unsigned DEN_W      = TIME_W + PPR_W;
  localparam int unsigned RPM_W      = 33;
  localparam int unsigned HELD_W     = 3;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Hundredths of rpm: 60 s * 1e6 us * 100.
  localparam logic [RPM_W-1:0] RPM_CENTI_NUM = 33'd6000000000;

  // Configuration reset values.
  localparam logic [PPR_W-1:0]  PPR_RST     = 16'd1;
  localparam logic [MINP_W-1:0] MIN_PER_RST = 20'd8000;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1500000;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    EDGE_FIRST    = 2'd0,
    EDGE_ACCEPTED = 2'd1,
    EDGE_GLITCH   = 2'd2,
    EDGE_QUERY    = 2'd3
  } edge_status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PPR        = 2'd0,
    REG_MIN_PERIOD = 2'd1,
    REG_TIMEOUT    = 2'd2
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic med_step;
    logic mul;
    logic div_start;
    logic load_out;
  } tmr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic med_last;
    logic div_done;
    logic out_free;
  } tmr_stat_t;

  // One result item.
  typedef struct packed {
    edge_status_e        edge_status;
    logic [RPM_W-1:0]    rpm_centi;
    logic [TIME_W-1:0]   median_period_us;
    logic [TIME_W-1:0]   recent_period_us;
    logic [TIME_W-1:0]   edge_count;
    logic [TIME_W-1:0]   glitch_count;
    logic [HELD_W-1:0]   periods_held;
  } tmr_result_t;

endpackage

/* design/tmr_if.sv */
// Channel interfaces of the tachometer median rpm block: input items,
// result items and configuration writes. Depends on tmr_pkg for widths.

interface tmr_item_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [tmr_pkg::TIME_W-1:0] time_us;

  modport source (output valid, opcode, time_us, input ready);
  modport sink   (input valid, opcode, time_us, output ready);
endinterface

interface tmr_result_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 edge_status;
  logic [tmr_pkg::RPM_W-1:0]  rpm_centi;
  logic [tmr_pkg::TIME_W-1:0] median_period_us;
  logic [tmr_pkg::TIME_W-1:0] recent_period_us;
  logic [tmr_pkg::TIME_W-1:0] edge_count;
  logic [tmr_pkg::TIME_W-1:0] glitch_count;
  logic [tmr_pkg::HELD_W-1:0] periods_held;

  modport source (output valid, edge_status, rpm_centi, median_period_us, recent_period_us,
                  edge_count, glitch_count, periods_held, input ready);
  modport sink   (input valid, edge_status, rpm_centi, median_period_us, recent_period_us,
                  edge_count, glitch_count, periods_held, output ready);
endinterface

interface tmr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tmr_pkg::REG_IDX_W-1:0]  reg_idx;
  logic [tmr_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

/* design/tmr_div.sv */
// Restoring divider that computes RPM_CENTI_NUM / divisor, one quotient bit per cycle.
// Depends on tmr_pkg for the numerator and widths.
module tmr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tmr_pkg::DEN_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [tmr_pkg::RPM_W-1:0]    quotient_o
);
  import tmr_pkg::*;

  localparam int unsigned STEP_W = $clog2(RPM_W);

  logic [DEN_W:0]     rem_q, rem_d;
  logic [RPM_W-1:0]   num_q, num_d;
  logic [RPM_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DEN_W:0]     trial;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DEN_W-1:0], num_q[RPM_W-1]};
    if (start_i) begin
      rem_d  = '0;
      num_d  = RPM_CENTI_NUM;
      quo_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[RPM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[RPM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[RPM_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(RPM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/tmr_ctrl.sv */
// Controller state machine of the tachometer median rpm block.
// Sequences capture, update, median scan, multiply, divide and output load.
// Depends on tmr_pkg for the command and status structs.
module tmr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  tmr_pkg::tmr_stat_t stat_i,
  output tmr_pkg::tmr_cmd_t  cmd_o
);
  import tmr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_UPDATE   = 7'b0000010,
    S_MEDIAN   = 7'b0000100,
    S_MUL      = 7'b0001000,
    S_DIV_GO   = 7'b0010000,
    S_DIV_WAIT = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_MEDIAN;
      end
      S_MEDIAN: begin
        cmd_o.med_step = 1'b1;
        if (stat_i.med_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign item_ready_o = (state_q == S_IDLE);

endmodule

/* design/tmr_datapath.sv */
// Datapath of the tachometer median rpm block: configuration registers, edge
// state, period ring, median scan, rpm multiply and divide, result register.
// Depends on tmr_pkg and instantiates tmr_div.
module tmr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tmr_pkg::tmr_cmd_t               cmd_i,
  output tmr_pkg::tmr_stat_t              stat_o,
  input  logic                            opcode_i,
  input  logic [tmr_pkg::TIME_W-1:0]      time_us_i,
  input  logic                            cfg_we_i,
  input  logic [tmr_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tmr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output tmr_pkg::tmr_result_t            res_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i
);
  import tmr_pkg::*;

  // Configuration registers.
  logic [PPR_W-1:0]  ppr_q;
  logic [MINP_W-1:0] min_per_q;
  logic [TIME_W-1:0] timeout_q;

  // Captured item.
  logic              op_q;
  logic [TIME_W-1:0] now_q;

  // Edge tracking state.
  logic [TIME_W-1:0]     ring_q [MEDIAN_DEPTH];
  logic [RING_IDX_W-1:0] wr_idx_q;
  logic [CNT_W-1:0]      count_q;
  logic [TIME_W-1:0]     last_edge_q;
  logic                  have_ref_q;
  logic [TIME_W-1:0]     latest_q;
  logic [TIME_W-1:0]     edges_q;
  logic [TIME_W-1:0]     glitches_q;
  edge_status_e          status_q;

  // Median scan and rpm.
  logic [RING_IDX_W-1:0] med_k_q;
  logic [TIME_W-1:0]     med_q;
  logic [DEN_W-1:0]      den_q;
  logic                  rpm_ok_q;
  logic [TIME_W-1:0]     cand;
  logic [CNT_W-1:0]      cand_pos;
  logic [TIME_W-1:0]     dt;
  logic [TIME_W-1:0]     since_edge;
  logic                  div_done;
  logic [RPM_W-1:0]      quotient;

  // Result register.
  tmr_result_t res_q;
  logic        res_valid_q;

  assign dt         = now_q - last_edge_q;
  assign since_edge = now_q - last_edge_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= PPR_RST;
      min_per_q <= MIN_PER_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PPR:        ppr_q     <= cfg_data_i[PPR_W-1:0];
        REG_MIN_PERIOD: min_per_q <= cfg_data_i[MINP_W-1:0];
        REG_TIMEOUT:    timeout_q <= cfg_data_i[TIME_W-1:0];
        default:        ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      now_q <= time_us_i;
    end
  end

  // Edge processing: first edge, glitch rejection or a new period.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEDIAN_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      wr_idx_q    <= '0;
      count_q     <= '0;
      last_edge_q <= '0;
      have_ref_q  <= 1'b0;
      latest_q    <= '0;
      edges_q     <= '0;
      glitches_q  <= '0;
      status_q    <= EDGE_QUERY;
    end else if (cmd_i.update) begin
      if (op_q == OP_QUERY) begin
        status_q <= EDGE_QUERY;
      end else begin
        edges_q <= edges_q + TIME_W'(1);
        if (!have_ref_q) begin
          have_ref_q  <= 1'b1;
          last_edge_q <= now_q;
          status_q    <= EDGE_FIRST;
        end else if (dt < TIME_W'(min_per_q)) begin
          glitches_q <= glitches_q + TIME_W'(1);
          status_q   <= EDGE_GLITCH;
        end else begin
          latest_q         <= dt;
          ring_q[wr_idx_q] <= dt;
          wr_idx_q         <= (wr_idx_q == RING_IDX_W'(MEDIAN_DEPTH - 1)) ? '0
                              : wr_idx_q + RING_IDX_W'(1);
          if (count_q < CNT_W'(MEDIAN_DEPTH)) begin
            count_q <= count_q + CNT_W'(1);
          end
          last_edge_q <= now_q;
          status_q    <= EDGE_ACCEPTED;
        end
      end
    end
  end

  // Sorted position of the candidate entry: smaller entries plus equal
  // entries that sit earlier in the ring, so ties keep a stable order.
  assign cand = ring_q[med_k_q];
  always_comb begin
    cand_pos = '0;
    for (int j = 0; j < MEDIAN_DEPTH; j++) begin
      if (CNT_W'(j) < count_q) begin
        if ((ring_q[j] < cand) ||
            ((ring_q[j] == cand) && (RING_IDX_W'(j) < med_k_q))) begin
          cand_pos = cand_pos + CNT_W'(1);
        end
      end
    end
  end

  // Median scan, one candidate per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      med_k_q <= '0;
      med_q   <= '0;
    end else if (cmd_i.med_step) begin
      med_k_q <= med_k_q + RING_IDX_W'(1);
      if ((CNT_W'(med_k_q) < count_q) && (cand_pos == (count_q >> 1))) begin
        med_q <= cand;
      end
    end
  end

  // Divisor and validity of the rpm reading.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      den_q    <= DEN_W'(med_q) * DEN_W'(ppr_q);
      rpm_ok_q <= (count_q != '0) && (ppr_q != '0) && (med_q != '0) &&
                  (since_edge <= timeout_q);
    end
  end

  tmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Result register; the next item may run while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.edge_status      <= status_q;
      res_q.rpm_centi        <= rpm_ok_q ? quotient : '0;
      res_q.median_period_us <= med_q;
      res_q.recent_period_us <= latest_q;
      res_q.edge_count       <= edges_q;
      res_q.glitch_count     <= glitches_q;
      res_q.periods_held     <= HELD_W'(count_q);
    end
  end

  assign stat_o.med_last = (med_k_q == RING_IDX_W'(MEDIAN_DEPTH - 1));
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !res_valid_q || res_ready_i;
  assign res_o           = res_q;
  assign res_valid_o     = res_valid_q;

endmodule

/* design/tachometer_median_rpm.sv */
// Tachometer period filter with median speed readout, top level.
// Depends on tmr_pkg, tmr_if, tmr_ctrl and tmr_datapath.
// Usage:
//   item_i carries a tach edge (opcode 0) or a speed query (opcode 1) with a
//   microsecond timestamp. Each transfer on item_i yields exactly one transfer
//   on result_o with status, rpm in hundredths, median and latest period, edge
//   and glitch counts and the number of held periods.
//   cfg_i writes the pulses per revolution (index 0), min_period_us (1) and
//   timeout_us (2); it is always ready and must only be used while no item is in flight.
// Processing order and throughput:
//   After its item transfer, an item passes through an update step, a median
//   scan of the ring, one multiply, one divider start, a 33-step restoring
//   divider (one quotient bit per cycle), a wait to see it finish and one load.
//   item_i is ready again the cycle after the load, so a new item is taken only
//   once the previous one has been loaded into the result register.
// Reset and stall:
//   Reset clears all counters, the period ring and the reference edge, and
//   loads the register defaults. If result_o stalls, the finished result waits
//   in its output register and the next item may still be taken; that item
//   then waits before its own result load until the register is free.
module tachometer_median_rpm (
  input  logic         clk_i,
  input  logic         rst_ni,
  tmr_cfg_if.sink      cfg_i,
  tmr_item_if.sink     item_i,
  tmr_result_if.source result_o
);
  import tmr_pkg::*;

  tmr_cmd_t    cmd;
  tmr_stat_t   stat;
  tmr_result_t res;
  logic        item_ready;
  logic        res_valid;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = item_ready;

  tmr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  tmr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (item_i.opcode),
    .time_us_i   (item_i.time_us),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.reg_idx),
    .cfg_data_i  (cfg_i.wdata),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready)
  );

  // Result channel.
  assign result_o.valid            = res_valid;
  assign result_o.edge_status      = res.edge_status;
  assign result_o.rpm_centi        = res.rpm_centi;
  assign result_o.median_period_us = res.median_period_us;
  assign result_o.recent_period_us = res.recent_period_us;
  assign result_o.edge_count       = res.edge_count;
  assign result_o.glitch_count     = res.glitch_count;
  assign result_o.periods_held     = res.periods_held;

  // An item transfer starts work, so the input closes on the next cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("item input still ready after a transfer");

  // The ring never reports more periods than it holds.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.periods_held <= HELD_W'(MEDIAN_DEPTH)))
    else $error("periods_held beyond ring depth");

  // A nonzero speed needs a held, nonzero median.
  a_rpm_needs_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.rpm_centi != '0)) |->
      ((result_o.median_period_us != '0) && (result_o.periods_held != '0)))
    else $error("rpm reported without a median period");

endmodule

/* verif/tachometer_median_rpm_tb.sv */
// Self-checking testbench for the tachometer median rpm block.
// Drives tach edges, speed queries and register writes, and predicts every reading.
// Depends on tmr_pkg and the channel interfaces in tmr_if.
module tachometer_median_rpm_tb;
  import tmr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register index that the block has no register behind.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS_PER_MODE = 342;
  localparam int unsigned SETUPS_PER_MODE = 3;

  logic clk_i;
  logic rst_ni;

  tmr_item_if   item_ch ();
  tmr_result_if result_ch ();
  tmr_cfg_if    cfg_ch ();

  tachometer_median_rpm i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  // Register copies that the predictor works from.
  logic [PPR_W-1:0]  cfg_ppr        = PPR_RST;
  logic [MINP_W-1:0] cfg_min_period = MIN_PER_RST;
  logic [TIME_W-1:0] cfg_timeout    = TIMEOUT_RST;

  // Predicted filter state.
  logic [TIME_W-1:0] ring_periods [MEDIAN_DEPTH];
  int unsigned       ring_wr     = 0;
  int unsigned       ring_fill   = 0;
  logic [TIME_W-1:0] ref_time    = '0;
  logic              ref_valid   = 1'b0;
  logic [TIME_W-1:0] newest_period = '0;
  logic [TIME_W-1:0] tach_edges    = '0;
  logic [TIME_W-1:0] tach_glitches = '0;

  tmr_result_t pending_readings [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned readings_seen = 0;
  int unsigned stall_cycles  = 0;

  // Timeline of the random traffic.
  logic [TIME_W-1:0] now_us     = '0;
  int unsigned       nominal_us = 10000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one item to the predicted state and return the reading it yields.
  function automatic tmr_result_t predict_reading(opcode_e op, logic [TIME_W-1:0] t);
    tmr_result_t       r;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] sorted [MEDIAN_DEPTH];
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] med;
    logic [63:0]       den;
    logic [63:0]       rpm;
    int                i;
    int                j;
    rpm = '0;
    med = '0;
    if (op == OP_EDGE) begin
      tach_edges = tach_edges + 1;
      if (!ref_valid) begin
        ref_valid = 1'b1;
        ref_time = t;
        r.edge_status = EDGE_FIRST;
      end else begin
        dt = t - ref_time;
        if (dt < {12'd0, cfg_min_period}) begin
          tach_glitches = tach_glitches + 1;
          r.edge_status = EDGE_GLITCH;
        end else begin
          newest_period = dt;
          ring_periods[ring_wr] = dt;
          ring_wr = (ring_wr + 1) % MEDIAN_DEPTH;
          if (ring_fill < MEDIAN_DEPTH) ring_fill++;
          ref_time = t;
          r.edge_status = EDGE_ACCEPTED;
        end
      end
    end else begin
      r.edge_status = EDGE_QUERY;
    end

    // Median of the held periods; the upper middle one for an even count.
    if (ring_fill != 0) begin
      for (i = 0; i < ring_fill; i++) sorted[i] = ring_periods[i];
      for (i = 1; i < ring_fill; i++) begin
        key = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      med = sorted[ring_fill / 2];
    end

    // Speed reads zero without periods, with a zero divisor or past the timeout.
    if (ring_fill != 0 && cfg_ppr != 0 && med != 0 && (t - ref_time) <= cfg_timeout) begin
      den = {32'd0, med} * {48'd0, cfg_ppr};
      rpm = {31'd0, RPM_CENTI_NUM} / den;
    end

    r.rpm_centi        = rpm[RPM_W-1:0];
    r.median_period_us = med;
    r.recent_period_us = newest_period;
    r.edge_count       = tach_edges;
    r.glitch_count     = tach_glitches;
    r.periods_held     = HELD_W'(ring_fill);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on reading %0d: %s is %0d, expected %0d", readings_seen, field, got,
             want);
    mismatches++;
  endtask

  // Send one item; called at a falling edge, returns at the falling edge after the transfer.
  task automatic send_item(opcode_e op, logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid   = 1'b1;
    item_ch.opcode  = op;
    item_ch.time_us = t;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    pending_readings.push_back(predict_reading(op, t));
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted reading has been checked.
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
  endtask

  // One register write; only issued while no item is in flight.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid   = 1'b1;
    cfg_ch.reg_idx = idx;
    cfg_ch.wdata   = value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_PPR:        cfg_ppr = value[PPR_W-1:0];
      REG_MIN_PERIOD: cfg_min_period = value[MINP_W-1:0];
      REG_TIMEOUT:    cfg_timeout = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Readings from reset: first edge, glitch at the threshold, even and odd counts,
  // the exact timeout boundary, timestamp wrap and a ring that wraps over.
  task automatic test_startup_readings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(OP_QUERY, 32'd0);
    send_item(OP_EDGE, 32'd0);
    send_item(OP_EDGE, 32'd7999);
    send_item(OP_EDGE, 32'd8000);
    send_item(OP_EDGE, 32'd28000);
    send_item(OP_EDGE, 32'd38000);
    send_item(OP_QUERY, 32'd38000 + 32'd1500000);
    send_item(OP_QUERY, 32'd38000 + 32'd1500001);
    send_item(OP_EDGE, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'h0000_1FFF);
    send_item(OP_EDGE, 32'h0000_1FFE);
    send_item(OP_QUERY, 32'h0000_1FFE);
    wait_drained();
  endtask

  // Register extremes: largest divisor, one-microsecond timeout, top speed,
  // zero pulses per revolution, zero median, masked values and an unused index.
  task automatic test_register_extremes();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_PPR, 32'd65535);
    write_reg(REG_MIN_PERIOD, 32'd1);
    write_reg(REG_TIMEOUT, 32'd1);
    for (k = 100; k <= 104; k++) send_item(OP_EDGE, 32'(k));
    send_item(OP_QUERY, 32'd105);
    send_item(OP_QUERY, 32'd106);
    wait_drained();

    write_reg(REG_PPR, 32'd1);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'd105);
    wait_drained();
    write_reg(REG_PPR, 32'd0);
    send_item(OP_QUERY, 32'd105);
    wait_drained();

    // A zero threshold lets equal timestamps enter the ring as zero periods.
    write_reg(REG_PPR, 32'd1);
    write_reg(REG_MIN_PERIOD, 32'd0);
    for (k = 0; k < 3; k++) send_item(OP_EDGE, 32'd105);
    wait_drained();

    write_reg(REG_SPARE, 32'd7);
    write_reg(REG_MIN_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_PPR, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'd105 + 32'h000F_FFFE);
    send_item(OP_EDGE, 32'd105 + 32'h000F_FFFF);
    wait_drained();
  endtask

  // Choose a register setting and a nominal tach period for one stretch of traffic.
  task automatic pick_random_setup();
    case ($urandom_range(3))
      0: begin
        write_reg(REG_PPR, $urandom_range(1, 4));
        write_reg(REG_MIN_PERIOD, 32'(MIN_PER_RST));
        write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
      end
      1: begin
        write_reg(REG_PPR, $urandom_range(1, 65535));
        write_reg(REG_MIN_PERIOD, $urandom_range(1, 1000));
        write_reg(REG_TIMEOUT, $urandom_range(1, 20000));
      end
      2: begin
        write_reg(REG_PPR, $urandom_range(1, 16));
        write_reg(REG_MIN_PERIOD, 32'd1000000);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
      end
      default: begin
        write_reg(REG_PPR, $urandom_range(0, 65535));
        write_reg(REG_MIN_PERIOD, $urandom);
        write_reg(REG_TIMEOUT, $urandom);
      end
    endcase
    nominal_us = cfg_min_period + 1 + $urandom_range(0, cfg_min_period);
    if ($urandom_range(3) == 0) now_us = $urandom;
  endtask

  // Mostly a plausible tach stream with jitter, glitches and queries, plus
  // long silences past the timeout and fully random items.
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    int unsigned      s;
    int unsigned      n;
    int unsigned      pick;
    opcode_e          op;
    logic [TIME_W-1:0] t;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (s = 0; s < SETUPS_PER_MODE; s++) begin
      wait_drained();
      pick_random_setup();
      for (n = 0; n < RANDOM_ITEMS_PER_MODE / SETUPS_PER_MODE; n++) begin
        pick = $urandom_range(99);
        op = OP_EDGE;
        if (pick < 50) begin
          t = now_us + nominal_us + $urandom_range(0, nominal_us / 8);
        end else if (pick < 62) begin
          t = now_us + (cfg_min_period == 0 ? 0 : $urandom_range(0, cfg_min_period - 1));
        end else if (pick < 85) begin
          op = OP_QUERY;
          t = now_us + $urandom_range(0, nominal_us);
        end else if (pick < 93) begin
          op = opcode_e'($urandom_range(1));
          t = now_us + cfg_timeout + $urandom_range(1, 1000);
        end else begin
          op = opcode_e'($urandom_range(1));
          t = $urandom;
        end
        now_us = t;
        send_item(op, t);
      end
    end
    wait_drained();
  endtask

  // Receiver side: ready changes at the falling edge.
  always @(negedge clk_i) begin
    result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every result transfer with the oldest predicted reading.
  always @(posedge clk_i) begin
    tmr_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending", 64'd1, 64'd0);
      end else begin
        want = pending_readings.pop_front();
        if (result_ch.edge_status !== want.edge_status)
          report_mismatch("edge_status", result_ch.edge_status, want.edge_status);
        if (result_ch.rpm_centi !== want.rpm_centi)
          report_mismatch("rpm_centi", result_ch.rpm_centi, want.rpm_centi);
        if (result_ch.median_period_us !== want.median_period_us)
          report_mismatch("median_period_us", result_ch.median_period_us,
                          want.median_period_us);
        if (result_ch.recent_period_us !== want.recent_period_us)
          report_mismatch("recent_period_us", result_ch.recent_period_us,
                          want.recent_period_us);
        if (result_ch.edge_count !== want.edge_count)
          report_mismatch("edge_count", result_ch.edge_count, want.edge_count);
        if (result_ch.glitch_count !== want.glitch_count)
          report_mismatch("glitch_count", result_ch.glitch_count, want.glitch_count);
        if (result_ch.periods_held !== want.periods_held)
          report_mismatch("periods_held", result_ch.periods_held, want.periods_held);
      end
      readings_seen++;
    end
  end

  // Watchdog: too long without any transfer on any channel ends the run.
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    foreach (ring_periods[k]) ring_periods[k] = '0;
    rst_ni          = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.opcode  = OP_EDGE;
    item_ch.time_us = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.reg_idx  = REG_PPR;
    cfg_ch.wdata    = '0;
    result_ch.ready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_startup_readings();
    test_register_extremes();
    // Slow receiver, then slow sender, then both at full rate.
    test_random_traffic(34, 87);
    test_random_traffic(87, 34);
    test_random_traffic(0, 0);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
